### rtl/ftem_pkg.sv
// shared types, constants and the crc32c byte step for the flow key table
`default_nettype none
package ftem_pkg;

    localparam int KEY_ADDR_W  = 64;
    localparam int KEY_PPP_W   = 40;
    localparam int GROUP_W     = 6;
    localparam int HASH_BYTES  = 16;
    localparam int HASH_CNT_W  = $clog2(HASH_BYTES);
    localparam int KEY_BITS    = HASH_BYTES * 8;
    localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;

    typedef struct packed {
        logic                  valid;
        logic [KEY_ADDR_W-1:0] addresses;
        logic [KEY_PPP_W-1:0]  ports_protocol;
        logic [GROUP_W-1:0]    group;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic load;
        logic clear_wr;
        logic hash_step;
        logic probe_init;
        logic advance;
        logic ins_wr;
        logic finish;
        logic fin_hit;
        logic fin_stored;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic hash_last;
        logic is_insert;
        logic group_ok;
        logic table_full;
        logic table_empty;
        logic slot_valid;
        logic key_match;
        logic probe_last;
    } status_t;

    // reflected crc32c, one byte
    function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        int          i;
        c = crc ^ {24'h0, data};
        for (i = 0; i < 8; i++)
        begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'h0);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

### rtl/five_tuple_exact_match_hash_table.sv
// top level of the five-tuple exact-match flow table
//
//  beat      handshake          carries
//  request   start & !busy      opcode, key fields, insert_group
//  result    done (one cycle)   hit, found_group, stored
//
// after reset the table runs a clearing pass that writes every slot, with busy high
// an item is loaded, then hashed over its 16 key bytes (crc32c one byte per cycle),
// then each probed slot is read and checked through the single entry ram
// early outs (full table, bad group, empty table) skip the probe walk
// done pulses the cycle after the decision; the receiver cannot stall it
`default_nettype none
module five_tuple_exact_match_hash_table
    import ftem_pkg::*;
#(
    parameter int TABLE_SLOTS = 1024,
    parameter int GROUP_COUNT = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               opcode,
    input  wire logic [31:0]        source_address,
    input  wire logic [31:0]        destination_address,
    input  wire logic [15:0]        source_port_number,
    input  wire logic [15:0]        destination_port_number,
    input  wire logic [7:0]         protocol_code,
    input  wire logic [GROUP_W-1:0] insert_group,
    output logic                    done,
    output logic                    hit,
    output logic [GROUP_W-1:0]      found_group,
    output logic                    stored
);

    cmd_t    cmd;
    status_t status;

    ftem_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    ftem_datapath #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .GROUP_COUNT (GROUP_COUNT)
    ) u_datapath (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .cmd                     (cmd),
        .status                  (status),
        .opcode                  (opcode),
        .source_address          (source_address),
        .destination_address     (destination_address),
        .source_port_number      (source_port_number),
        .destination_port_number (destination_port_number),
        .protocol_code           (protocol_code),
        .insert_group            (insert_group),
        .done                    (done),
        .hit                     (hit),
        .found_group             (found_group),
        .stored                  (stored)
    );

endmodule
`default_nettype wire

### rtl/ftem_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module ftem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### rtl/ftem_ctrl.sv
// controller state machine: clearing pass, hashing, probe walk
`default_nettype none
module ftem_ctrl
    import ftem_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire status_t status,
    output cmd_t         cmd
);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_HASH  = 5'b00100,
        ST_READ  = 5'b01000,
        ST_CHECK = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                cmd.hash_step = 1'b1;
                if (status.hash_last)
                begin
                    priority if (status.is_insert && (!status.group_ok || status.table_full))
                    begin
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else if (!status.is_insert && status.table_empty)
                    begin
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.probe_init = 1'b1;
                        state_next     = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                priority if (!status.slot_valid)
                begin
                    // empty slot ends both walks
                    cmd.finish = 1'b1;
                    if (status.is_insert)
                    begin
                        cmd.ins_wr     = 1'b1;
                        cmd.fin_stored = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
                else if (!status.is_insert && status.key_match)
                begin
                    cmd.finish  = 1'b1;
                    cmd.fin_hit = 1'b1;
                    state_next  = ST_IDLE;
                end
                else if (status.probe_last)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### rtl/ftem_datapath.sv
// datapath: key registers, crc, slot walk, entry store and result registers
`default_nettype none
module ftem_datapath
    import ftem_pkg::*;
#(
    parameter int TABLE_SLOTS = 1024,
    parameter int GROUP_COUNT = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cmd_t               cmd,
    output status_t                 status,
    input  wire logic               opcode,
    input  wire logic [31:0]        source_address,
    input  wire logic [31:0]        destination_address,
    input  wire logic [15:0]        source_port_number,
    input  wire logic [15:0]        destination_port_number,
    input  wire logic [7:0]         protocol_code,
    input  wire logic [GROUP_W-1:0] insert_group,
    output logic                    done,
    output logic                    hit,
    output logic [GROUP_W-1:0]      found_group,
    output logic                    stored
);

    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int CNT_W  = SLOT_W + 1;

    logic                  op_reg;
    logic [KEY_ADDR_W-1:0] addr_reg;
    logic [KEY_PPP_W-1:0]  ppp_reg;
    logic [GROUP_W-1:0]    group_reg;
    logic [31:0]           crc_reg, crc_next;
    logic [HASH_CNT_W-1:0] byte_cnt_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [SLOT_W-1:0]     probe_reg;
    logic [CNT_W-1:0]      count_reg;
    logic                  done_reg;
    logic                  hit_reg;
    logic [GROUP_W-1:0]    found_reg;
    logic                  stored_reg;

    logic [KEY_BITS-1:0]   key_vec;
    logic [7:0]            hash_byte;
    logic                  ram_we;
    entry_t                ram_wdata;
    logic [ENTRY_W-1:0]    ram_rdata;
    entry_t                rd_entry;

    // byte i of the hashed key sits at bits 8*i +: 8
    assign key_vec = {24'h0, ppp_reg[7:0], ppp_reg[23:8], ppp_reg[39:24],
                      addr_reg[31:0], addr_reg[63:32]};
    assign hash_byte = key_vec[byte_cnt_reg*8 +: 8];
    assign crc_next  = crc32c_byte(crc_reg, hash_byte);

    assign rd_entry = entry_t'(ram_rdata);

    always_comb
    begin
        ram_we = cmd.clear_wr | cmd.ins_wr;
        if (cmd.clear_wr)
        begin
            ram_wdata = '0;
        end
        else
        begin
            ram_wdata.valid          = 1'b1;
            ram_wdata.addresses      = addr_reg;
            ram_wdata.ports_protocol = ppp_reg;
            ram_wdata.group          = group_reg;
        end
    end

    ftem_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (ram_wdata),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        status.clear_last  = (slot_reg == {SLOT_W{1'b1}});
        status.hash_last   = (byte_cnt_reg == HASH_CNT_W'(HASH_BYTES - 1));
        status.is_insert   = op_reg;
        status.group_ok    = ({1'b0, group_reg} < (GROUP_W + 1)'(GROUP_COUNT));
        status.table_full  = (count_reg == CNT_W'(TABLE_SLOTS));
        status.table_empty = (count_reg == '0);
        status.slot_valid  = rd_entry.valid;
        status.key_match   = (rd_entry.addresses == addr_reg) &&
                             (rd_entry.ports_protocol == ppp_reg);
        status.probe_last  = (probe_reg == {SLOT_W{1'b1}});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.clear_wr || cmd.advance)
            begin
                slot_reg <= slot_reg + 1'b1;
            end
            else if (cmd.probe_init)
            begin
                slot_reg <= crc_next[SLOT_W-1:0];
            end
            if (cmd.ins_wr)
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= opcode;
            addr_reg     <= {source_address, destination_address};
            ppp_reg      <= {source_port_number, destination_port_number, protocol_code};
            group_reg    <= insert_group;
            crc_reg      <= '0;
            byte_cnt_reg <= '0;
        end
        else if (cmd.hash_step)
        begin
            crc_reg      <= crc_next;
            byte_cnt_reg <= byte_cnt_reg + 1'b1;
        end
        if (cmd.probe_init)
        begin
            probe_reg <= '0;
        end
        else if (cmd.advance)
        begin
            probe_reg <= probe_reg + 1'b1;
        end
        if (cmd.finish)
        begin
            hit_reg    <= cmd.fin_hit;
            found_reg  <= cmd.fin_hit ? rd_entry.group : '0;
            stored_reg <= cmd.fin_stored;
        end
    end

    assign done        = done_reg;
    assign hit         = hit_reg;
    assign found_group = found_reg;
    assign stored      = stored_reg;

endmodule
`default_nettype wire

### tb/tb.sv
// testbench for the five-tuple exact-match flow table: directed and random key traffic
`timescale 1ns / 100ps
module tb;
    import ftem_pkg::GROUP_W;

    localparam int SLOTS       = 1024;
    localparam int GROUPS      = 64;
    localparam logic [31:0] CRC32C_REFLECTED = 32'h82F6_3B78;
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;
    localparam int DRAIN_CYCLES = 2 * SLOTS + 64;

    typedef struct packed {
        logic [31:0] saddr;
        logic [31:0] daddr;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  proto;
    } flow_key_t;

    typedef struct packed {
        logic               op;
        flow_key_t          key;
        logic [GROUP_W-1:0] group;
    } flow_item_t;

    typedef struct packed {
        logic               hit;
        logic [GROUP_W-1:0] group;
        logic               stored;
    } flow_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic opcode = 1'b0;
    logic [31:0] source_address = '0;
    logic [31:0] destination_address = '0;
    logic [15:0] source_port_number = '0;
    logic [15:0] destination_port_number = '0;
    logic [7:0] protocol_code = '0;
    logic [GROUP_W-1:0] insert_group = '0;
    logic done;
    logic hit;
    logic [GROUP_W-1:0] found_group;
    logic stored;

    // predictor copy of the table
    bit                 tbl_used [SLOTS];
    logic [63:0]        tbl_addr [SLOTS];
    logic [39:0]        tbl_ppp  [SLOTS];
    logic [GROUP_W-1:0] tbl_grp  [SLOTS];
    int                 tbl_entries = 0;

    flow_result_t expected_q[$];
    flow_key_t    known_keys[$];
    int           mismatch_count = 0;
    bit           gaps_on = 1'b1;

    five_tuple_exact_match_hash_table u_dut (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .start                   (start),
        .busy                    (busy),
        .opcode                  (opcode),
        .source_address          (source_address),
        .destination_address     (destination_address),
        .source_port_number      (source_port_number),
        .destination_port_number (destination_port_number),
        .protocol_code           (protocol_code),
        .insert_group            (insert_group),
        .done                    (done),
        .hit                     (hit),
        .found_group             (found_group),
        .stored                  (stored)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #120_000_000;
        $display("tb: errors");
        $finish;
    end

    task automatic report_error(input string msg);
        mismatch_count++;
        $display("%0t: %s", $time, msg);
    endtask

    // bit-serial reflected crc over the 16-byte key, lsb of byte 0 first
    function automatic logic [31:0] flow_key_crc(input flow_key_t key);
        logic [127:0] stream;
        logic [31:0]  c;
        logic         fb;
        int           i;
        stream = {24'h0, key.proto, key.dport, key.sport, key.daddr, key.saddr};
        c = 32'h0;
        for (i = 0; i < 128; i++)
        begin
            fb = c[0] ^ stream[i];
            c = c >> 1;
            if (fb)
                c = c ^ CRC32C_REFLECTED;
        end
        return c;
    endfunction

    function automatic flow_result_t flow_table_apply(input flow_item_t it);
        flow_result_t res;
        logic [31:0]  h;
        logic [31:0]  s;
        logic [63:0]  a;
        logic [39:0]  p;
        int           k;
        res = '0;
        h = flow_key_crc(it.key);
        a = {it.key.saddr, it.key.daddr};
        p = {it.key.sport, it.key.dport, it.key.proto};
        if (it.op == OP_INSERT)
        begin
            if (int'(it.group) < GROUPS)
            begin
                for (k = 0; k < SLOTS; k++)
                begin
                    s = (h + k) & (SLOTS - 1);
                    if (!tbl_used[s])
                    begin
                        tbl_used[s] = 1'b1;
                        tbl_addr[s] = a;
                        tbl_ppp[s] = p;
                        tbl_grp[s] = it.group;
                        tbl_entries++;
                        res.stored = 1'b1;
                        break;
                    end
                end
            end
        end
        else if (tbl_entries != 0)
        begin
            for (k = 0; k < SLOTS; k++)
            begin
                s = (h + k) & (SLOTS - 1);
                if (!tbl_used[s])
                    break;
                if (tbl_addr[s] == a && tbl_ppp[s] == p)
                begin
                    res.hit = 1'b1;
                    res.group = tbl_grp[s];
                    break;
                end
            end
        end
        return res;
    endfunction

    function automatic logic [31:0] rand_bits(input int w);
        logic [31:0] mask;
        int          r;
        mask = 32'((64'd1 << w) - 1);
        r = $urandom_range(0, 7);
        if (r == 0)
            return 32'h0;
        if (r == 1)
            return mask;
        return $urandom & mask;
    endfunction

    function automatic flow_key_t rand_key();
        flow_key_t key;
        key.saddr = rand_bits(32);
        key.daddr = rand_bits(32);
        key.sport = 16'(rand_bits(16));
        key.dport = 16'(rand_bits(16));
        key.proto = 8'(rand_bits(8));
        return key;
    endfunction

    function automatic flow_item_t make_item(input logic op, input flow_key_t key,
                                             input int grp);
        flow_item_t it;
        it.op = op;
        it.key = key;
        it.group = GROUP_W'(grp);
        return it;
    endfunction

    // one request beat; start is left high so back-to-back beats need no toggle
    task automatic send_beat(input flow_item_t it);
        if (!start)
            start <= 1'b1;
        opcode <= it.op;
        source_address <= it.key.saddr;
        destination_address <= it.key.daddr;
        source_port_number <= it.key.sport;
        destination_port_number <= it.key.dport;
        protocol_code <= it.key.proto;
        insert_group <= it.group;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        expected_q = {expected_q, flow_table_apply(it)};
        if (it.op == OP_INSERT)
            known_keys = {known_keys, it.key};
        if (gaps_on && $urandom_range(0, 99) < 8)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clk);
        end
    endtask

    task automatic wait_all_results();
        if (start)
            start <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    // result checker: one beat per done pulse
    always @(posedge clk)
    begin
        flow_result_t want;
        if (rst_n && done)
        begin
            if (expected_q.size() == 0)
                report_error("result with no request outstanding");
            else
            begin
                want = expected_q.pop_front();
                if (hit !== want.hit)
                    report_error($sformatf("hit got %b expected %b", hit, want.hit));
                if (found_group !== want.group)
                    report_error($sformatf("found_group got %0d expected %0d",
                                           found_group, want.group));
                if (stored !== want.stored)
                    report_error($sformatf("stored got %b expected %b", stored, want.stored));
            end
        end
    end

    task automatic test_empty_table();
        flow_key_t zero_key;
        flow_key_t ones_key;
        zero_key = '0;
        ones_key = '1;
        send_beat(make_item(OP_LOOKUP, zero_key, 0));
        send_beat(make_item(OP_LOOKUP, ones_key, GROUPS - 1));
        send_beat(make_item(OP_LOOKUP, rand_key(), $urandom_range(0, GROUPS - 1)));
        wait_all_results();
    endtask

    task automatic test_field_extremes();
        flow_key_t zero_key;
        flow_key_t ones_key;
        flow_key_t k;
        zero_key = '0;
        ones_key = '1;
        send_beat(make_item(OP_INSERT, zero_key, 0));
        send_beat(make_item(OP_INSERT, ones_key, GROUPS - 1));
        send_beat(make_item(OP_LOOKUP, zero_key, GROUPS - 1));
        send_beat(make_item(OP_LOOKUP, ones_key, 0));
        // one field off from a stored key must miss
        k = ones_key; k.saddr = 32'hFFFF_FFFE;
        send_beat(make_item(OP_LOOKUP, k, 0));
        k = ones_key; k.daddr = 32'h7FFF_FFFF;
        send_beat(make_item(OP_LOOKUP, k, 0));
        k = zero_key; k.sport = 16'h0001;
        send_beat(make_item(OP_LOOKUP, k, 0));
        k = zero_key; k.dport = 16'h8000;
        send_beat(make_item(OP_LOOKUP, k, 0));
        k = ones_key; k.proto = 8'hFE;
        send_beat(make_item(OP_LOOKUP, k, 0));
        wait_all_results();
    endtask

    task automatic test_duplicate_keys();
        flow_key_t k;
        k = rand_key();
        send_beat(make_item(OP_INSERT, k, 21));
        send_beat(make_item(OP_INSERT, k, 42));
        send_beat(make_item(OP_LOOKUP, k, 42));
        wait_all_results();
    endtask

    // mostly inserts with mixed lookups until the table is full or 5000 items are sent
    task automatic test_random_fill();
        flow_key_t k;
        int        n;
        int        r;
        int        bitpos;
        n = 0;
        while (tbl_entries < SLOTS && n < 5000)
        begin
            gaps_on = !(n >= 400 && n < 600);
            if (n == 700)
                wait_all_results();
            r = $urandom_range(0, 99);
            if (r < 85)
            begin
                if ($urandom_range(0, 99) < 15)
                    k = known_keys[$urandom_range(0, known_keys.size() - 1)];
                else
                    k = rand_key();
                send_beat(make_item(OP_INSERT, k, $urandom_range(0, GROUPS - 1)));
            end
            else
            begin
                r = $urandom_range(0, 3);
                if (r < 2)
                    k = known_keys[$urandom_range(0, known_keys.size() - 1)];
                else if (r == 2)
                begin
                    k = known_keys[$urandom_range(0, known_keys.size() - 1)];
                    bitpos = $urandom_range(0, $bits(flow_key_t) - 1);
                    k[bitpos] = ~k[bitpos];
                end
                else
                    k = rand_key();
                send_beat(make_item(OP_LOOKUP, k, $urandom_range(0, GROUPS - 1)));
            end
            n++;
        end
        gaps_on = 1'b1;
        wait_all_results();
    endtask

    // full table: inserts are refused, absent keys walk every slot
    task automatic test_full_table();
        int i;
        send_beat(make_item(OP_INSERT, rand_key(), $urandom_range(0, GROUPS - 1)));
        send_beat(make_item(OP_INSERT, known_keys[0], GROUPS - 1));
        for (i = 0; i < 6; i++)
            send_beat(make_item(OP_LOOKUP, rand_key(), $urandom_range(0, GROUPS - 1)));
        for (i = 0; i < 6; i++)
            send_beat(make_item(OP_LOOKUP, known_keys[$urandom_range(0, known_keys.size() - 1)],
                                $urandom_range(0, GROUPS - 1)));
        wait_all_results();
    endtask

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
            tbl_used[i] = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_table();
        test_field_extremes();
        test_duplicate_keys();
        test_random_fill();
        test_full_table();
        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_q.size() != 0)
            report_error($sformatf("%0d results never arrived", expected_q.size()));
        if (mismatch_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
